>>> hw/rtl/stacked_bar_column_renderer_unit_defines.svh
// assertion macros used by the renderer rtl (sbcr_emit)
`ifndef STACKED_BAR_COLUMN_RENDERER_UNIT_DEFINES_SVH
`define STACKED_BAR_COLUMN_RENDERER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SBCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stacked bar renderer check failed");
// next-cycle implication
`define SBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stacked bar renderer check failed");
`else
`define SBCR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/sbcr_pkg.sv
package sbcr_pkg;

    localparam int DATA_W    = 24;
    localparam int COL_IN_W  = 2;
    localparam int PIX_W     = 6;
    localparam int MODE_W    = 2;
    localparam int FRAC_BITS = 8;
    localparam int LANES     = 3;
    localparam int DIV_STEPS = 4;
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 32;

    localparam int LANE_BOTTOM = 0;
    localparam int LANE_MIDDLE = 1;
    localparam int LANE_TOP    = 2;

    localparam logic [MODE_W-1:0] MODE_ZIGZAG_LL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZIGZAG_UR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_ZIGZAG_UR;

    localparam logic [7:0] CAP_DIM = 8'd245;

    typedef struct packed {
        logic [DATA_W-1:0] cap;
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] middle;
        logic [DATA_W-1:0] bottom;
    } seg_colors_t;

    typedef struct packed {
        logic [COL_IN_W-1:0] column;
        logic                has_cap;
        logic                err;
        logic [LANES-1:0]    neg;
        seg_colors_t         colors;
    } item_info_t;

    function automatic logic [7:0] dim_channel(input logic [7:0] c);
        return (c > CAP_DIM) ? (c - CAP_DIM) : 8'd0;
    endfunction

    function automatic logic [DATA_W-1:0] dim_color(input logic [DATA_W-1:0] c);
        return {dim_channel(c[23:16]), dim_channel(c[15:8]), dim_channel(c[7:0])};
    endfunction

endpackage

>>> hw/rtl/sbcr_prep.sv
module sbcr_prep #(
    parameter int COLUMNS         = 4,
    parameter int LEDS_PER_COLUMN = 12,
    parameter int AV_W            = 4,
    parameter int FULL_W          = 20,
    parameter int DIV_W           = 28
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [sbcr_pkg::S_TDATA_W-1:0]                in_data,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output sbcr_pkg::item_info_t                          out_info,
    output logic [FULL_W-1:0]                             out_full,
    output logic [sbcr_pkg::LANES-1:0][DIV_W-1:0]         out_mag
);

    localparam int PROD_W = sbcr_pkg::DATA_W + AV_W;
    localparam int DW     = sbcr_pkg::DATA_W;
    localparam int CW     = sbcr_pkg::COL_IN_W;

    logic                                  valid_reg;
    sbcr_pkg::item_info_t                  info_reg, info_next;
    logic [FULL_W-1:0]                     full_reg, full_next;
    logic [sbcr_pkg::LANES-1:0][DIV_W-1:0] mag_reg, mag_next;

    logic [AV_W-1:0]   avail;
    logic [PROD_W-1:0] full_prod;
    logic [DW-1:0]     val;
    logic [DW-1:0]     mag;
    logic [CW-1:0]     column;

    always_comb
    begin
        column = in_data[CW-1:0];
        info_next.colors.bottom = in_data[CW + 4*DW +: DW];
        info_next.colors.middle = in_data[CW + 5*DW +: DW];
        info_next.colors.upper  = in_data[CW + 6*DW +: DW];
        info_next.colors.cap    = in_data[CW + 7*DW +: DW];
        info_next.has_cap       = (info_next.colors.cap != '0);
        avail = info_next.has_cap ? AV_W'(LEDS_PER_COLUMN - 1) : AV_W'(LEDS_PER_COLUMN);

        // full scale = value_per_led * avail, 8 fractional bits dropped
        full_prod = PROD_W'(in_data[CW + 3*DW +: DW]) * PROD_W'(avail);
        full_next = full_prod[sbcr_pkg::FRAC_BITS +: FULL_W];
        info_next.err = (full_next == '0);

        // columns past the last one are saturated
        if (int'(column) > COLUMNS - 1)
        begin
            info_next.column = CW'(COLUMNS - 1);
        end
        else
        begin
            info_next.column = column;
        end

        // sign and magnitude of value * avail for the dividers
        for (int l = 0; l < sbcr_pkg::LANES; l++)
        begin
            val = in_data[CW + l*DW +: DW];
            info_next.neg[l] = val[DW-1];
            mag = val[DW-1] ? (~val + 1'b1) : val;
            mag_next[l] = DIV_W'(mag) * DIV_W'(avail);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            info_reg <= info_next;
            full_reg <= full_next;
            mag_reg  <= mag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_info  = info_reg;
    assign out_full  = full_reg;
    assign out_mag   = mag_reg;

endmodule

>>> hw/rtl/sbcr_div_stage.sv
module sbcr_div_stage #(
    parameter int FULL_W = 20,
    parameter int DIV_W  = 28
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  sbcr_pkg::item_info_t                   in_info,
    input  logic [FULL_W-1:0]                      in_full,
    input  logic [sbcr_pkg::LANES-1:0][FULL_W-1:0] in_rem,
    input  logic [sbcr_pkg::LANES-1:0][DIV_W-1:0]  in_quo,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output sbcr_pkg::item_info_t                   out_info,
    output logic [FULL_W-1:0]                      out_full,
    output logic [sbcr_pkg::LANES-1:0][FULL_W-1:0] out_rem,
    output logic [sbcr_pkg::LANES-1:0][DIV_W-1:0]  out_quo
);

    logic                                   valid_reg;
    sbcr_pkg::item_info_t                   info_reg;
    logic [FULL_W-1:0]                      full_reg;
    logic [sbcr_pkg::LANES-1:0][FULL_W-1:0] rem_reg, rem_next;
    logic [sbcr_pkg::LANES-1:0][DIV_W-1:0]  quo_reg, quo_next;

    // restoring division, DIV_STEPS quotient bits per stage; dividend shifts out of
    // the top of quo while quotient bits shift in at the bottom
    always_comb
    begin
        logic [FULL_W:0]   t;
        logic [FULL_W-1:0] r;
        logic [DIV_W-1:0]  q;
        for (int l = 0; l < sbcr_pkg::LANES; l++)
        begin
            r = in_rem[l];
            q = in_quo[l];
            for (int s = 0; s < sbcr_pkg::DIV_STEPS; s++)
            begin
                t = {r, q[DIV_W-1]};
                q = {q[DIV_W-2:0], 1'b0};
                if (t >= {1'b0, in_full})
                begin
                    t    = t - {1'b0, in_full};
                    q[0] = 1'b1;
                end
                r = t[FULL_W-1:0];
            end
            rem_next[l] = r;
            quo_next[l] = q;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            info_reg <= in_info;
            full_reg <= in_full;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_info  = info_reg;
    assign out_full  = full_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

>>> hw/rtl/sbcr_emit.sv
`include "stacked_bar_column_renderer_unit_defines.svh"

module sbcr_emit #(
    parameter int COLUMNS         = 4,
    parameter int LEDS_PER_COLUMN = 12,
    parameter int DIV_W           = 28
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [sbcr_pkg::MODE_W-1:0]           layout_mode,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  sbcr_pkg::item_info_t                  in_info,
    input  logic [sbcr_pkg::LANES-1:0][DIV_W-1:0] in_quo,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sbcr_pkg::PIX_W-1:0]            out_index,
    output logic [sbcr_pkg::DATA_W-1:0]           out_color,
    output logic                                  out_last,
    output logic                                  out_err
);

    localparam int SUM_W = DIV_W + 3;
    localparam int RW    = $clog2(LEDS_PER_COLUMN);
    localparam int IDX_W = RW + 5;

    // combine stage: signed counts accumulated bottom to top
    logic                                  comb_valid_reg;
    sbcr_pkg::item_info_t                  comb_info_reg;
    logic [sbcr_pkg::LANES-1:0][SUM_W-1:0] comb_cnt_reg, comb_cnt_next;
    logic                                  comb_ready;

    // hold stage: item being walked row by row
    logic                                  hold_valid_reg;
    sbcr_pkg::item_info_t                  hold_info_reg;
    logic [sbcr_pkg::LANES-1:0][SUM_W-1:0] hold_cnt_reg;
    logic [RW-1:0]                         row_reg;
    logic                                  hold_ready;
    logic                                  emit;
    logic                                  last_row;

    // output register
    logic                                  out_valid_reg;
    logic [sbcr_pkg::PIX_W-1:0]            out_index_reg, out_index_next;
    logic [sbcr_pkg::DATA_W-1:0]           out_color_reg, out_color_next;
    logic                                  out_last_reg;
    logic                                  out_err_reg;

    logic [SUM_W-1:0] q_ext;
    logic [SUM_W-1:0] q_sgn;
    logic [SUM_W-1:0] row_ext;
    logic [RW-1:0]    row_flip;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] col_x;
    logic [IDX_W-1:0] col_mir;
    logic [IDX_W-1:0] idx;

    always_comb
    begin
        for (int l = 0; l < sbcr_pkg::LANES; l++)
        begin
            q_ext = {3'b000, in_quo[l]};
            q_sgn = in_info.neg[l] ? (~q_ext + 1'b1) : q_ext;
            if (l == sbcr_pkg::LANE_BOTTOM)
            begin
                comb_cnt_next[l] = q_sgn;
            end
            else
            begin
                comb_cnt_next[l] = q_sgn + comb_cnt_next[l-1];
            end
        end
    end

    assign comb_ready = !comb_valid_reg || hold_ready;
    assign in_ready   = comb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_valid_reg <= 1'b0;
        end
        else if (comb_ready)
        begin
            comb_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (comb_ready && in_valid)
        begin
            comb_info_reg <= in_info;
            comb_cnt_reg  <= comb_cnt_next;
        end
    end

    assign last_row   = (row_reg == RW'(LEDS_PER_COLUMN - 1));
    assign emit       = hold_valid_reg && (!out_valid_reg || out_ready);
    assign hold_ready = !hold_valid_reg || (emit && last_row);

    // pixel color and mapped position for the current row
    always_comb
    begin
        row_ext = SUM_W'(row_reg);
        if (hold_info_reg.err)
        begin
            out_color_next = '0;
        end
        else if (hold_info_reg.has_cap && last_row)
        begin
            out_color_next = sbcr_pkg::dim_color(hold_info_reg.colors.cap);
        end
        else if ($signed(row_ext) < $signed(hold_cnt_reg[sbcr_pkg::LANE_BOTTOM]))
        begin
            out_color_next = hold_info_reg.colors.bottom;
        end
        else if ($signed(row_ext) < $signed(hold_cnt_reg[sbcr_pkg::LANE_MIDDLE]))
        begin
            out_color_next = hold_info_reg.colors.middle;
        end
        else if ($signed(row_ext) < $signed(hold_cnt_reg[sbcr_pkg::LANE_TOP]))
        begin
            out_color_next = hold_info_reg.colors.upper;
        end
        else
        begin
            out_color_next = '0;
        end

        row_flip = RW'(LEDS_PER_COLUMN - 1) - row_reg;
        col_x    = IDX_W'(hold_info_reg.column);
        col_mir  = IDX_W'(COLUMNS - 1) - col_x;
        case (layout_mode)
            sbcr_pkg::MODE_ZIGZAG_LL:
            begin
                base = IDX_W'(row_reg) * IDX_W'(COLUMNS);
                idx  = row_reg[0] ? (base + col_mir) : (base + col_x);
            end
            sbcr_pkg::MODE_ZIGZAG_UR:
            begin
                base = IDX_W'(row_flip) * IDX_W'(COLUMNS);
                idx  = row_flip[0] ? (base + col_x) : (base + col_mir);
            end
            default:
            begin
                // single column, also the unused mode code
                base = '0;
                idx  = IDX_W'(row_reg);
            end
        endcase
        out_index_next = idx[sbcr_pkg::PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (hold_ready)
            begin
                hold_valid_reg <= comb_valid_reg;
            end
            if (emit)
            begin
                row_reg <= last_row ? '0 : (row_reg + 1'b1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_ready && comb_valid_reg)
        begin
            hold_info_reg <= comb_info_reg;
            hold_cnt_reg  <= comb_cnt_reg;
        end
        if (emit)
        begin
            out_index_reg <= out_index_next;
            out_color_reg <= out_color_next;
            out_last_reg  <= last_row;
            out_err_reg   <= hold_info_reg.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_color = out_color_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

    `SBCR_ASSERT_IMPL(a_err_black, clk, rst_n, out_valid_reg && out_err_reg, out_color_reg == '0)
    `SBCR_ASSERT_IMPL(a_row_range, clk, rst_n, hold_valid_reg, row_reg <= RW'(LEDS_PER_COLUMN - 1))
    `SBCR_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid_reg && out_ready && !out_last_reg, out_valid_reg)
    `SBCR_ASSERT_NEXT(a_row_hold, clk, rst_n, out_valid_reg && !out_ready, $stable(row_reg))

endmodule

>>> hw/rtl/stacked_bar_column_renderer_unit.sv
// Stacked bar column renderer. Each input transaction asks for one LED column
// drawn as a bottom/middle/top stacked bar with an optional dimmed cap on the
// topmost LED (cap color zero means no cap, otherwise one LED is reserved).
// Full scale is value_per_led * available LEDs with the 8 fraction bits
// dropped; each segment's lit count is value * available / full scale,
// truncated toward zero, and the counts stack bottom to top. The column comes
// out as LEDS_PER_COLUMN pixel transactions, bottom row first, tlast on the
// top row; a zero full scale gives black pixels with tuser set on all of them.
// Rate: one pixel transaction per cycle while m_tready is high, from the
// single output port. Inputs enter a pipeline of one multiply stage,
// ceil((28)/4) = 7 divider stages at 4 quotient bits each (three dividers
// side by side), a count combine stage, a row walker and an output
// register; up to about ten columns can be in flight. layout_mode (reset 1)
// selects the LED chain mapping. layout_mode must be written only while the
// block is idle; the block itself does not enforce this.
module stacked_bar_column_renderer_unit #(
    parameter int COLUMNS         = 4,
    parameter int LEDS_PER_COLUMN = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write: layout_mode
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbcr_pkg::MODE_W-1:0]         cfg_data,
    // column requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // column[1:0], bottom_value, middle_value, top_value, value_per_led,
    // bottom_color, middle_color, upper_color, cap_color (24 bits each), zero pad
    input  logic [sbcr_pkg::S_TDATA_W-1:0]      s_tdata,
    // pixel writes
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_index[5:0], pixel_color[29:6], zero pad
    output logic [sbcr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // scale_error
    output logic                                m_tuser
);

    localparam int AV_W       = $clog2(LEDS_PER_COLUMN + 1);
    localparam int MAG_W      = sbcr_pkg::DATA_W + AV_W;
    localparam int FULL_W     = sbcr_pkg::DATA_W + AV_W - sbcr_pkg::FRAC_BITS;
    localparam int DIV_STAGES = (MAG_W + sbcr_pkg::DIV_STEPS - 1) / sbcr_pkg::DIV_STEPS;
    localparam int DIV_W      = DIV_STAGES * sbcr_pkg::DIV_STEPS;
    localparam int PAD_W      = sbcr_pkg::M_TDATA_W - sbcr_pkg::PIX_W - sbcr_pkg::DATA_W;

    // layout mode register
    logic [sbcr_pkg::MODE_W-1:0] layout_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_mode_reg <= sbcr_pkg::MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            layout_mode_reg <= cfg_data;
        end
    end

    // divider chain, index 0 is the multiply stage output
    logic [DIV_STAGES:0]                   dv_valid;
    logic [DIV_STAGES:0]                   dv_ready;
    sbcr_pkg::item_info_t                  dv_info [DIV_STAGES+1];
    logic [FULL_W-1:0]                     dv_full [DIV_STAGES+1];
    logic [sbcr_pkg::LANES-1:0][FULL_W-1:0] dv_rem [DIV_STAGES+1];
    logic [sbcr_pkg::LANES-1:0][DIV_W-1:0]  dv_quo [DIV_STAGES+1];

    logic [sbcr_pkg::PIX_W-1:0]  pix_index;
    logic [sbcr_pkg::DATA_W-1:0] pix_color;

    // multiply stage: avail, full scale, value magnitudes
    sbcr_prep #(
        .COLUMNS         (COLUMNS),
        .LEDS_PER_COLUMN (LEDS_PER_COLUMN),
        .AV_W            (AV_W),
        .FULL_W          (FULL_W),
        .DIV_W           (DIV_W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .out_info  (dv_info[0]),
        .out_full  (dv_full[0]),
        .out_mag   (dv_quo[0])
    );

    assign dv_rem[0] = '0;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        sbcr_div_stage #(
            .FULL_W (FULL_W),
            .DIV_W  (DIV_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .in_ready  (dv_ready[g]),
            .in_info   (dv_info[g]),
            .in_full   (dv_full[g]),
            .in_rem    (dv_rem[g]),
            .in_quo    (dv_quo[g]),
            .out_valid (dv_valid[g+1]),
            .out_ready (dv_ready[g+1]),
            .out_info  (dv_info[g+1]),
            .out_full  (dv_full[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_quo   (dv_quo[g+1])
        );
    end

    // signed counts, row walker and output register
    sbcr_emit #(
        .COLUMNS         (COLUMNS),
        .LEDS_PER_COLUMN (LEDS_PER_COLUMN),
        .DIV_W           (DIV_W)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .layout_mode (layout_mode_reg),
        .in_valid    (dv_valid[DIV_STAGES]),
        .in_ready    (dv_ready[DIV_STAGES]),
        .in_info     (dv_info[DIV_STAGES]),
        .in_quo      (dv_quo[DIV_STAGES]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (pix_index),
        .out_color   (pix_color),
        .out_last    (m_tlast),
        .out_err     (m_tuser)
    );

    assign m_tdata = {PAD_W'(0), pix_color, pix_index};

endmodule

>>> bench/tb_stacked_bar_column_renderer_unit.sv
module tb_stacked_bar_column_renderer_unit;

    localparam int COLUMNS         = 4;
    localparam int LEDS_PER_COLUMN = 12;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DW              = sbcr_pkg::DATA_W;
    localparam int CW              = sbcr_pkg::COL_IN_W;
    localparam int PW              = sbcr_pkg::PIX_W;
    localparam int MW              = sbcr_pkg::MODE_W;
    // mode three is not named in the package; it maps like single column
    localparam logic [sbcr_pkg::MODE_W-1:0] MODE_SINGLE_ALT = 2'd3;

    typedef struct {
        logic [CW-1:0]        column;
        logic signed [DW-1:0] bottom_value;
        logic signed [DW-1:0] middle_value;
        logic signed [DW-1:0] top_value;
        logic [DW-1:0]        value_per_led;
        logic [DW-1:0]        bottom_color;
        logic [DW-1:0]        middle_color;
        logic [DW-1:0]        upper_color;
        logic [DW-1:0]        cap_color;
    } column_req_t;

    typedef struct {
        logic [PW-1:0] index;
        logic [DW-1:0] color;
        logic          last;
        logic          scale_error;
    } pixel_write_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [MW-1:0]                    cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [sbcr_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [sbcr_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;

    column_req_t  column_req_q[$];
    pixel_write_t pixel_expect_q[$];
    logic [MW-1:0] layout_now = sbcr_pkg::MODE_RESET;
    int sender_idle = 1;
    int sink_idle = 1;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    stacked_bar_column_renderer_unit #(
        .COLUMNS         (COLUMNS),
        .LEDS_PER_COLUMN (LEDS_PER_COLUMN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("error: %s expected %0h got %0h (cycle %0d)", what, want, got,
                     cycle_count);
    endtask

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap(int level);
        int p;
        if (level == 0)
            return 0;
        p = int'($urandom_range(0, 99));
        if (p < ((level == 2) ? 30 : 60))
            return 0;
        if (p < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [DW-1:0] cap_dimmed(logic [DW-1:0] c);
        logic [DW-1:0] d;
        logic [7:0] ch;
        for (int k = 0; k < 3; k++)
        begin
            ch = c[k*8 +: 8];
            d[k*8 +: 8] = (ch > 8'd245) ? ch - 8'd245 : 8'd0;
        end
        return d;
    endfunction

    function automatic logic [PW-1:0] led_position(int x, int y, logic [MW-1:0] mode);
        int r;
        int pos;
        case (mode)
            sbcr_pkg::MODE_ZIGZAG_LL:
            begin
                r = y;
                pos = r * COLUMNS + ((r % 2) ? (COLUMNS - 1 - x) : x);
            end
            sbcr_pkg::MODE_ZIGZAG_UR:
            begin
                r = LEDS_PER_COLUMN - 1 - y;
                pos = r * COLUMNS + ((r % 2) ? x : (COLUMNS - 1 - x));
            end
            default: pos = y;
        endcase
        return pos[PW-1:0];
    endfunction

    // expected pixel writes for one column request, bottom row first
    function automatic void render_column(column_req_t r, logic [MW-1:0] mode);
        longint avail;
        longint full;
        longint n_bottom;
        longint n_middle;
        longint n_top;
        int x;
        logic bad_scale;
        pixel_write_t px;
        avail = (r.cap_color != '0) ? longint'(LEDS_PER_COLUMN - 1)
                                    : longint'(LEDS_PER_COLUMN);
        full = (longint'(r.value_per_led) * avail) >> sbcr_pkg::FRAC_BITS;
        bad_scale = (full == 0);
        n_bottom = 0;
        n_middle = 0;
        n_top = 0;
        if (!bad_scale)
        begin
            n_bottom = (longint'(r.bottom_value) * avail) / full;
            n_middle = (longint'(r.middle_value) * avail) / full + n_bottom;
            n_top = (longint'(r.top_value) * avail) / full + n_middle;
        end
        x = (r.column > COLUMNS - 1) ? COLUMNS - 1 : int'(r.column);
        for (int row = 0; row < LEDS_PER_COLUMN; row++)
        begin
            if (bad_scale)
                px.color = '0;
            else if (row >= avail)
                px.color = cap_dimmed(r.cap_color);
            else if (row < n_bottom)
                px.color = r.bottom_color;
            else if (row < n_middle)
                px.color = r.middle_color;
            else if (row < n_top)
                px.color = r.upper_color;
            else
                px.color = '0;
            px.index = led_position(x, row, mode);
            px.last = (row == LEDS_PER_COLUMN - 1);
            px.scale_error = bad_scale;
            pixel_expect_q.push_back(px);
        end
    endfunction

    function automatic column_req_t make_req(int col, int b, int m, int t, int per,
                                             int cb, int cm, int ct, int cap);
        column_req_t r;
        r.column = CW'(col);
        r.bottom_value = DW'(b);
        r.middle_value = DW'(m);
        r.top_value = DW'(t);
        r.value_per_led = DW'(per);
        r.bottom_color = DW'(cb);
        r.middle_color = DW'(cm);
        r.upper_color = DW'(ct);
        r.cap_color = DW'(cap);
        return r;
    endfunction

    function automatic column_req_t random_req();
        column_req_t r;
        int kind;
        int fe;
        kind = int'($urandom_range(0, 99));
        r.column = CW'($urandom_range(0, 3));
        r.bottom_color = DW'($urandom_range(0, 24'hFFFFFF));
        r.middle_color = DW'($urandom_range(0, 24'hFFFFFF));
        r.upper_color = DW'($urandom_range(0, 24'hFFFFFF));
        r.cap_color = ($urandom_range(0, 9) < 4) ? '0 : DW'($urandom_range(1, 24'hFFFFFF));
        if (kind < 15)
        begin
            // anything goes
            r.value_per_led = DW'($urandom_range(0, 24'hFFFFFF));
            r.bottom_value = DW'($urandom_range(0, 24'hFFFFFF));
            r.middle_value = DW'($urandom_range(0, 24'hFFFFFF));
            r.top_value = DW'($urandom_range(0, 24'hFFFFFF));
        end
        else if (kind < 30)
        begin
            // scale at or near zero
            r.value_per_led = DW'($urandom_range(0, 23));
            r.bottom_value = DW'($urandom_range(0, 24'hFFFFFF));
            r.middle_value = DW'($urandom_range(0, 40));
            r.top_value = DW'($urandom_range(0, 24'hFFFFFF));
        end
        else
        begin
            // values near full scale so the bar lands inside the column
            r.value_per_led = DW'($urandom_range(16, 16'h4000));
            fe = (int'(r.value_per_led) * LEDS_PER_COLUMN) >> sbcr_pkg::FRAC_BITS;
            r.bottom_value = DW'($urandom_range(0, fe / 2 + 1));
            r.middle_value = DW'($urandom_range(0, fe / 2 + 1));
            r.top_value = DW'($urandom_range(0, fe / 2 + 1));
            if ($urandom_range(0, 4) == 0)
                r.middle_value = -r.middle_value;
            if ($urandom_range(0, 9) == 0)
                r.bottom_value = -r.bottom_value;
        end
        return r;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        int gap_left;
        column_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                req = column_req_q.pop_front();
                render_column(req, layout_now);
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (column_req_q.size() > 0)
                begin
                    // the head of the queue stays there until accepted
                    req = column_req_q[0];
                    s_tdata <= {6'd0, req.cap_color, req.upper_color, req.middle_color,
                                req.bottom_color, req.value_per_led, req.top_value,
                                req.middle_value, req.bottom_value, req.column};
                    s_tvalid <= 1'b1;
                    gap_left = pick_gap(sender_idle);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once, so the pipeline backs up into s_tready
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // pixel monitor and sink
    always @(posedge clk)
    begin
        int stall_left;
        pixel_write_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pixel_expect_q.size() == 0)
                    report_mismatch("pixel with nothing pending", 32'd0, m_tdata);
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (m_tdata[5:0] !== want.index)
                        report_mismatch("pixel_index", 32'(want.index), 32'(m_tdata[5:0]));
                    if (m_tdata[29:6] !== want.color)
                        report_mismatch("pixel_color", 32'(want.color), 32'(m_tdata[29:6]));
                    if (m_tlast !== want.last)
                        report_mismatch("last", 32'(want.last), 32'(m_tlast));
                    if (m_tuser !== want.scale_error)
                        report_mismatch("scale_error", 32'(want.scale_error), 32'(m_tuser));
                end
            end
            if (hold_left > 0)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap(sink_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // all requests sent and every pixel back, plus the pipeline's depth
    task automatic wait_drained();
        while (column_req_q.size() != 0 || s_tvalid || pixel_expect_q.size() != 0
               || hold_left > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_layout(logic [MW-1:0] mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        layout_now = mode;
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++)
            column_req_q.push_back(random_req());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed columns under the reset layout
        column_req_q.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
        column_req_q.push_back(make_req(3, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF,
                                        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        column_req_q.push_back(make_req(1, 24'h800000, 24'h800000, 24'h800000, 24'h100,
                                        24'h123456, 24'h654321, 24'hABCDEF, 0));
        // cap channels straddling the dimming threshold
        column_req_q.push_back(make_req(2, 3, 4, 5, 24'h100,
                                        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hF6F5F4));
        column_req_q.push_back(make_req(0, 1, 1, 1, 23, 24'h111111, 24'h222222,
                                        24'h333333, 24'h000001));
        column_req_q.push_back(make_req(1, 1, 1, 1, 23, 24'h111111, 24'h222222,
                                        24'h333333, 0));
        // middle segment pulls the stack back down
        column_req_q.push_back(make_req(2, 8, -3, 5, 24'h100, 24'hAA0000, 24'h00AA00,
                                        24'h0000AA, 24'hFFFFFF));
        column_req_q.push_back(make_req(3, -2, 6, 3, 24'h100, 24'hAA0000, 24'h00AA00,
                                        24'h0000AA, 0));
        column_req_q.push_back(make_req(0, 5, 5, 5, 24'hFFFFFF, 24'h010203, 24'h040506,
                                        24'h070809, 0));
        column_req_q.push_back(make_req(1, 24'h7FFFFF, 0, 0, 24'h100, 24'h0F0F0F,
                                        24'hF0F0F0, 24'h555555, 24'h0000F5));
        column_req_q.push_back(make_req(2, 4, 4, 4, 24'h200, 24'hFFFFFF, 24'h808080,
                                        24'h010101, 24'hFFFFFF));
        column_req_q.push_back(make_req(3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h80,
                                        24'hC0FFEE, 24'hBEEF00, 24'h00FACE, 24'h000100));
        column_req_q.push_back(make_req(0, 12, 0, 0, 24'h100, 24'h7FFFFF, 0, 0, 0));
        column_req_q.push_back(make_req(3, 0, 0, 11, 24'h100, 0, 0, 24'h800000, 24'h800000));

        sender_idle <= 1;
        sink_idle <= 1;
        write_layout(sbcr_pkg::MODE_ZIGZAG_LL);
        queue_random(35);

        // no idling on either side, then a long receiver hold-off
        sender_idle <= 0;
        sink_idle <= 0;
        write_layout(sbcr_pkg::MODE_SINGLE);
        hold_arm <= 1'b1;
        queue_random(30);

        sender_idle <= 2;
        sink_idle <= 2;
        write_layout(MODE_SINGLE_ALT);
        queue_random(30);

        sender_idle <= 1;
        sink_idle <= 2;
        write_layout(sbcr_pkg::MODE_ZIGZAG_UR);
        queue_random(30);

        sender_idle <= 2;
        sink_idle <= 1;
        write_layout(sbcr_pkg::MODE_ZIGZAG_LL);
        queue_random(30);

        wait_drained();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
